[rtl/wss_pkg.sv]
// shared types and codes of the windowed section sender
package wss_pkg;

  localparam int KindW = 3;
  localparam int NetW = 8;
  localparam int SeqW = 3;
  localparam int AddrW = 32;
  localparam int LenW = 3;
  localparam int SizeW = 16;

  localparam logic [KindW-1:0] KIND_START_OK = 3'd0;
  localparam logic [KindW-1:0] KIND_BUSY = 3'd1;
  localparam logic [KindW-1:0] KIND_PARAM_ERR = 3'd2;
  localparam logic [KindW-1:0] KIND_DATA = 3'd3;
  localparam logic [KindW-1:0] KIND_PAUSE_ALARM = 3'd4;
  localparam logic [KindW-1:0] KIND_DONE_ALARM = 3'd5;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CAPTURE = 2'd2;
  localparam logic [1:0] CMD_REPORT = 2'd3;

  localparam logic [2:0] FLOW_SEND = 3'd0;
  localparam logic [2:0] FLOW_WAIT = 3'd1;
  localparam logic [2:0] FLOW_RESEND = 3'd2;
  localparam logic [2:0] FLOW_DONE = 3'd3;
  localparam logic [2:0] FLOW_ABORT = 3'd4;

  // work handed from the front to the back; size carries the window byte count, or the echoed size of a start-ok job
  typedef struct packed {
    logic win;
    logic [KindW-1:0] kind;
    logic [NetW-1:0] dest;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
  } job_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [NetW-1:0] dest;
    logic [SeqW-1:0] seq;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0] len;
    logic [SizeW-1:0] size;
    logic last;
  } result_t;

endpackage

[rtl/wss_fifo.sv]
// small first-in first-out queue of flip-flops
module wss_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/wss_front.sv]
// front stage: takes requests, keeps the sender state and queues work
module wss_front #(
  parameter int SectionBytes = 6,
  parameter int WindowSections = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 accept_i,
  input  logic [1:0]           command_i,
  input  logic [7:0]           net_id_i,
  input  logic [2:0]           request_code_i,
  input  logic [31:0]          capture_addr_i,
  input  logic [15:0]          capture_size_i,
  output wss_pkg::job_t        job_o,
  output logic                 job_push_o
);
  import wss_pkg::*;

  localparam int Slots = (WindowSections < 8) ? WindowSections : 8;
  localparam int WinBytes = Slots * SectionBytes;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_READY = 3'd2;
  localparam logic [2:0] ST_ACTIVE = 3'd3;
  localparam logic [2:0] ST_RESEND = 3'd4;
  localparam logic [2:0] ST_PAUSE = 3'd5;
  localparam logic [2:0] ST_ABORT = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [7:0] limit_q;
  logic armed_q, armed_d;
  logic [2:0] state_q, state_d;
  logic [7:0] reply_q, reply_d;
  logic [31:0] base_q, base_d;
  logic [15:0] size_q, size_d;
  logic [15:0] send_off_q, send_off_d;
  logic [15:0] win_off_q, win_off_d;
  logic [7:0] pause_q, pause_d;

  // tick intermediate values
  logic [2:0] st1;
  logic [15:0] off1, win1, rem, win_bytes;
  logic [7:0] pc1;
  logic tick_disarm, tick_alarm;

  always_comb begin
    st1 = state_q;
    off1 = send_off_q;
    win1 = win_off_q;
    pc1 = pause_q;
    tick_disarm = 1'b0;
    tick_alarm = 1'b0;
    case (state_q)
      ST_IDLE, ST_ABORT, ST_DONE: begin
        tick_disarm = 1'b1;
      end
      ST_READY: begin
        st1 = ST_ACTIVE;
      end
      ST_ACTIVE: begin
        win1 = send_off_q;
      end
      ST_RESEND: begin
        off1 = win_off_q;
        st1 = ST_ACTIVE;
      end
      ST_PAUSE: begin
        pc1 = (pause_q == 8'hff) ? pause_q : pause_q + 1'b1;
        if (pc1 >= limit_q) begin
          tick_alarm = 1'b1;
          tick_disarm = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rem = size_q - off1;
    win_bytes = (rem > 16'(WinBytes)) ? 16'(WinBytes) : rem;
  end

  always_comb begin
    armed_d = armed_q;
    state_d = state_q;
    reply_d = reply_q;
    base_d = base_q;
    size_d = size_q;
    send_off_d = send_off_q;
    win_off_d = win_off_q;
    pause_d = pause_q;
    job_push_o = 1'b0;
    job_o = '0;
    job_o.dest = net_id_i;
    if (accept_i) begin
      case (command_i)
        CMD_TICK: begin
          if (armed_q) begin
            state_d = st1;
            send_off_d = off1;
            win_off_d = win1;
            pause_d = pc1;
            if (tick_alarm) begin
              job_push_o = 1'b1;
              job_o.kind = KIND_PAUSE_ALARM;
              job_o.dest = reply_q;
            end
            if (!tick_disarm && st1 == ST_ACTIVE) begin
              if (off1 < size_q) begin
                job_push_o = 1'b1;
                job_o.win = 1'b1;
                job_o.kind = KIND_DATA;
                job_o.dest = reply_q;
                job_o.addr = base_q + {16'd0, off1};
                job_o.size = win_bytes;
                send_off_d = off1 + win_bytes;
              end
              pause_d = '0;
              state_d = ST_PAUSE;
            end
            if (tick_disarm) begin
              armed_d = 1'b0;
              state_d = ST_IDLE;
              base_d = '0;
              size_d = '0;
              send_off_d = '0;
              win_off_d = '0;
              pause_d = '0;
            end
          end
        end
        CMD_START: begin
          job_push_o = 1'b1;
          if (request_code_i >= 3'd3) begin
            job_o.kind = KIND_PARAM_ERR;
          end else if (armed_q) begin
            job_o.kind = KIND_BUSY;
          end else begin
            job_o.kind = KIND_START_OK;
            job_o.size = capture_size_i;
            armed_d = 1'b1;
            state_d = ST_NOT_READY;
            reply_d = net_id_i;
          end
        end
        CMD_CAPTURE: begin
          if (armed_q) begin
            base_d = capture_addr_i;
            size_d = capture_size_i;
            state_d = ST_READY;
            send_off_d = '0;
            win_off_d = '0;
            pause_d = '0;
          end
        end
        CMD_REPORT: begin
          if (armed_q) begin
            case (request_code_i)
              FLOW_SEND, FLOW_WAIT: begin
                if (send_off_q >= size_q) begin
                  state_d = ST_DONE;
                  job_push_o = 1'b1;
                  job_o.kind = KIND_DONE_ALARM;
                end else begin
                  state_d = (request_code_i == FLOW_SEND) ? ST_ACTIVE : ST_PAUSE;
                end
              end
              FLOW_RESEND: begin
                state_d = ST_RESEND;
              end
              FLOW_DONE, FLOW_ABORT: begin
                armed_d = 1'b0;
                state_d = ST_IDLE;
                base_d = '0;
                size_d = '0;
                send_off_d = '0;
                win_off_d = '0;
                pause_d = '0;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 8'd35;
      armed_q <= 1'b0;
      state_q <= ST_IDLE;
      reply_q <= '0;
      base_q <= '0;
      size_q <= '0;
      send_off_q <= '0;
      win_off_q <= '0;
      pause_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      armed_q <= armed_d;
      state_q <= state_d;
      reply_q <= reply_d;
      base_q <= base_d;
      size_q <= size_d;
      send_off_q <= send_off_d;
      win_off_q <= win_off_d;
      pause_q <= pause_d;
    end
  end

endmodule

[rtl/wss_back.sv]
// back stage: turns queued work into results, one section per cycle while the result queue has room
module wss_back #(
  parameter int SectionBytes = 6,
  parameter int WindowSections = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wss_pkg::job_t    job_i,
  input  logic             job_valid_i,
  output logic             job_pop_o,
  output wss_pkg::result_t res_o,
  output logic             res_push_o,
  input  logic             res_full_i
);
  import wss_pkg::*;

  localparam int Slots = (WindowSections < 8) ? WindowSections : 8;
  localparam int RemW = $clog2(Slots * SectionBytes + 1);
  localparam int SecW = $clog2(SectionBytes + 1);

  logic busy_q, busy_d;
  logic [SeqW-1:0] seq_q, seq_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [NetW-1:0] dest_q, dest_d;

  logic [SeqW-1:0] cur_seq;
  logic [AddrW-1:0] cur_addr;
  logic [RemW-1:0] cur_rem;
  logic [NetW-1:0] cur_dest;
  logic [SecW-1:0] sec_len;
  logic sec_last, win_go, single_go;

  // a window's first section comes straight from the queue head
  assign cur_seq = busy_q ? seq_q : '0;
  assign cur_addr = busy_q ? addr_q : job_i.addr;
  assign cur_rem = busy_q ? rem_q : RemW'(job_i.size);
  assign cur_dest = busy_q ? dest_q : job_i.dest;
  assign sec_last = (cur_rem <= RemW'(SectionBytes));
  assign sec_len = sec_last ? SecW'(cur_rem) : SecW'(SectionBytes);

  assign win_go = (busy_q || (job_valid_i && job_i.win)) && !res_full_i;
  assign single_go = !busy_q && job_valid_i && !job_i.win && !res_full_i;
  assign job_pop_o = single_go || (win_go && !busy_q);
  assign res_push_o = win_go || single_go;

  always_comb begin
    res_o = '0;
    if (win_go) begin
      res_o.kind = KIND_DATA;
      res_o.dest = cur_dest;
      res_o.seq = cur_seq;
      res_o.addr = cur_addr;
      res_o.len = LenW'(sec_len);
      res_o.last = sec_last;
    end else begin
      res_o.kind = job_i.kind;
      res_o.dest = job_i.dest;
      res_o.size = job_i.size;
      res_o.last = 1'b1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    seq_d = seq_q;
    addr_d = addr_q;
    rem_d = rem_q;
    dest_d = dest_q;
    if (win_go) begin
      busy_d = !sec_last;
      seq_d = cur_seq + 1'b1;
      addr_d = cur_addr + AddrW'(sec_len);
      rem_d = cur_rem - RemW'(sec_len);
      dest_d = cur_dest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    addr_q <= addr_d;
    rem_q <= rem_d;
    dest_q <= dest_d;
  end

endmodule

[rtl/windowed_section_sender.sv]
// Windowed section sender: a request is accepted on any cycle in which push is high and
// full is low, one per cycle while the four-entry work queue between the front and back
// stages has room. Start requests, capture events and flow reports are settled in the front
// stage in the accepting cycle; a tick that opens a window queues one job from which the
// back stage emits one data section per cycle while the result queue has room; a window
// holds up to 8 sections, and every other job yields one result. Results wait in a
// two-entry result queue and are read with pop while empty is low. pause_limit is written
// through the cfg channel, which is always ready, and resets to 35.
module windowed_section_sender #(
  parameter int SECTION_BYTES = 6,
  parameter int WINDOW_SECTIONS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [7:0]  net_id_i,
  input  logic [2:0]  request_code_i,
  input  logic [31:0] capture_addr_i,
  input  logic [15:0] capture_size_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  dest_net_o,
  output logic [2:0]  seq_num_o,
  output logic [31:0] section_addr_o,
  output logic [2:0]  section_length_o,
  output logic [15:0] reported_size_o,
  output logic        last_o
);
  import wss_pkg::*;

  job_t job_in, job_head;
  result_t res_in, res_head;
  logic job_push, job_pop, job_empty;
  logic res_push, res_full;
  logic accept;

  assign cfg_ready_o = 1'b1;
  assign accept = push && !full;

  wss_front #(
    .SectionBytes(SECTION_BYTES),
    .WindowSections(WINDOW_SECTIONS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_data_i,
    .accept_i(accept),
    .command_i,
    .net_id_i,
    .request_code_i,
    .capture_addr_i,
    .capture_size_i,
    .job_o(job_in),
    .job_push_o(job_push)
  );

  wss_fifo #(
    .Width($bits(job_t)),
    .Depth(4)
  ) u_job_q (
    .clk_i,
    .rst_ni,
    .push_i(job_push),
    .data_i(job_in),
    .full_o(full),
    .pop_i(job_pop),
    .data_o(job_head),
    .empty_o(job_empty)
  );

  wss_back #(
    .SectionBytes(SECTION_BYTES),
    .WindowSections(WINDOW_SECTIONS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .job_i(job_head),
    .job_valid_i(!job_empty),
    .job_pop_o(job_pop),
    .res_o(res_in),
    .res_push_o(res_push),
    .res_full_i(res_full)
  );

  wss_fifo #(
    .Width($bits(result_t)),
    .Depth(2)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i(res_push),
    .data_i(res_in),
    .full_o(res_full),
    .pop_i(pop),
    .data_o(res_head),
    .empty_o(empty)
  );

  assign result_kind_o = res_head.kind;
  assign dest_net_o = res_head.dest;
  assign seq_num_o = res_head.seq;
  assign section_addr_o = res_head.addr;
  assign section_length_o = res_head.len;
  assign reported_size_o = res_head.size;
  assign last_o = res_head.last;

`ifndef SYNTHESIS
  // every result other than a data section stands alone
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o != KIND_DATA) |-> last_o)
    else $error("non-data result without last");

  a_nondata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o != KIND_DATA) |->
      (seq_num_o == '0 && section_addr_o == '0 && section_length_o == '0))
    else $error("non-data result carries section fields");

  a_size_only_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o != KIND_START_OK) |-> reported_size_o == '0)
    else $error("size echoed outside a start-ok result");

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_kind_o <= KIND_DONE_ALARM))
    else $error("result kind out of range");
`endif

endmodule

[dv/windowed_section_sender_test.sv]
// testbench for the windowed section sender: queued requests, self-predicted results
`timescale 1ns / 100ps

module windowed_section_sender_test;
  import wss_pkg::*;

  localparam int SectionBytes = 6;
  localparam int WindowSlots = 8;
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 40;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_READY     = 3'd2,
    ST_ACTIVE    = 3'd3,
    ST_RESEND    = 3'd4,
    ST_PAUSE     = 3'd5,
    ST_ABORT     = 3'd6,
    ST_DONE      = 3'd7
  } engine_state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] net;
    logic [2:0] code;
    logic [31:0] addr;
    logic [15:0] size;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic [1:0] command_i = '0;
  logic [7:0] net_id_i = '0;
  logic [2:0] request_code_i = '0;
  logic [31:0] capture_addr_i = '0;
  logic [15:0] capture_size_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] result_kind_o;
  logic [7:0] dest_net_o;
  logic [2:0] seq_num_o;
  logic [31:0] section_addr_o;
  logic [2:0] section_length_o;
  logic [15:0] reported_size_o;
  logic last_o;

  windowed_section_sender uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .net_id_i        (net_id_i),
    .request_code_i  (request_code_i),
    .capture_addr_i  (capture_addr_i),
    .capture_size_i  (capture_size_i),
    .empty           (empty),
    .pop             (pop),
    .result_kind_o   (result_kind_o),
    .dest_net_o      (dest_net_o),
    .seq_num_o       (seq_num_o),
    .section_addr_o  (section_addr_o),
    .section_length_o(section_length_o),
    .reported_size_o (reported_size_o),
    .last_o          (last_o)
  );

  req_t pending_reqs[$];
  result_t due_results[$];
  int err_count = 0;
  int items_queued = 0;
  int stall_cycles = 0;
  int hold_req = 0;
  bit req_taken = 1'b0;
  bit res_taken = 1'b0;

  // predicted engine state
  logic [7:0] pause_lim = 8'd35;
  bit eng_armed = 1'b0;
  engine_state_e eng_state = ST_IDLE;
  logic [7:0] eng_reply = '0;
  logic [31:0] eng_base = '0;
  logic [15:0] eng_size = '0;
  logic [15:0] eng_offset = '0;
  logic [15:0] eng_window = '0;
  logic [7:0] eng_pauses = '0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    err_count++;
    $display("%0t mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  function automatic result_t make_result(input logic [2:0] kind, input logic [7:0] dest,
                                          input logic [2:0] seq, input logic [31:0] addr,
                                          input logic [2:0] len, input logic [15:0] size);
    result_t r;
    r = '0;
    r.kind = kind;
    r.dest = dest;
    r.seq = seq;
    r.addr = addr;
    r.len = len;
    r.size = size;
    return r;
  endfunction

  task automatic disarm_engine();
    eng_armed = 1'b0;
    eng_state = ST_IDLE;
    eng_base = '0;
    eng_size = '0;
    eng_offset = '0;
    eng_window = '0;
    eng_pauses = '0;
  endtask

  // works out every result one accepted request causes
  task automatic sender_step(input req_t r);
    result_t outs[$];
    int slot;
    int unsigned chunk;
    outs = {};
    case (r.cmd)
      CMD_TICK: begin
        if (eng_armed) begin
          case (eng_state)
            ST_IDLE, ST_ABORT, ST_DONE: disarm_engine();
            ST_READY: eng_state = ST_ACTIVE;
            ST_ACTIVE: eng_window = eng_offset;
            ST_RESEND: begin
              eng_offset = eng_window;
              eng_state = ST_ACTIVE;
            end
            ST_PAUSE: begin
              if (eng_pauses != 8'hFF) eng_pauses++;
              if (eng_pauses >= pause_lim) begin
                outs.push_back(make_result(KIND_PAUSE_ALARM, eng_reply, '0, '0, '0, '0));
                disarm_engine();
              end
            end
            default: ;
          endcase
          if (eng_state == ST_ACTIVE) begin
            for (slot = 0; slot < WindowSlots; slot++) begin
              if (eng_offset < eng_size) begin
                chunk = eng_size - eng_offset;
                if (chunk > SectionBytes) chunk = SectionBytes;
                outs.push_back(make_result(KIND_DATA, eng_reply, slot[2:0],
                                           eng_base + 32'(eng_offset), chunk[2:0], '0));
                eng_offset = eng_offset + 16'(chunk);
              end
            end
            eng_pauses = '0;
            eng_state = ST_PAUSE;
          end
        end
      end
      CMD_START: begin
        if (r.code >= 3'd3) begin
          outs.push_back(make_result(KIND_PARAM_ERR, r.net, '0, '0, '0, '0));
        end else if (eng_armed) begin
          outs.push_back(make_result(KIND_BUSY, r.net, '0, '0, '0, '0));
        end else begin
          eng_armed = 1'b1;
          eng_state = ST_NOT_READY;
          eng_reply = r.net;
          outs.push_back(make_result(KIND_START_OK, r.net, '0, '0, '0, r.size));
        end
      end
      CMD_CAPTURE: begin
        if (eng_armed) begin
          eng_base = r.addr;
          eng_size = r.size;
          eng_state = ST_READY;
          eng_offset = '0;
          eng_window = '0;
          eng_pauses = '0;
        end
      end
      default: begin
        if (eng_armed) begin
          case (r.code)
            FLOW_SEND, FLOW_WAIT: begin
              if (eng_offset >= eng_size) begin
                eng_state = ST_DONE;
                outs.push_back(make_result(KIND_DONE_ALARM, r.net, '0, '0, '0, '0));
              end else begin
                eng_state = (r.code == FLOW_SEND) ? ST_ACTIVE : ST_PAUSE;
              end
            end
            FLOW_RESEND: eng_state = ST_RESEND;
            FLOW_DONE, FLOW_ABORT: disarm_engine();
            default: ;
          endcase
        end
      end
    endcase
    if (outs.size() != 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) due_results.push_back(outs[i]);
  endtask

  // full-speed stretches mixed with random waits
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 17);
  endfunction

  // request driver
  int tx_gap = 0;
  int tx_burst = 0;
  always @(negedge clk_i) begin
    req_t nxt;
    if (rst_ni) begin
      if (!push || req_taken) begin
        req_taken = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          push <= 1'b1;
          command_i <= nxt.cmd;
          net_id_i <= nxt.net;
          request_code_i <= nxt.code;
          capture_addr_i <= nxt.addr;
          capture_size_i <= nxt.size;
          tx_gap = draw_gap(tx_burst);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    req_t acc;
    if (rst_ni && push && !full) begin
      acc.cmd = command_i;
      acc.net = net_id_i;
      acc.code = request_code_i;
      acc.addr = capture_addr_i;
      acc.size = capture_size_i;
      sender_step(acc);
      req_taken = 1'b1;
    end
  end

  // result receiver, with an optional long hold-off to back the block up
  int rx_gap = 0;
  int rx_burst = 0;
  int hold_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req != 0) begin
        hold_left = HoldCycles;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_taken = 1'b0;
        pop <= 1'b0;
      end else if (pop && res_taken) begin
        res_taken = 1'b0;
        rx_gap = draw_gap(rx_burst);
        pop <= (rx_gap == 0);
      end else if (!pop && rx_gap > 0) begin
        rx_gap--;
        pop <= (rx_gap == 0);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      res_taken = 1'b1;
      if (due_results.size() == 0) begin
        report_mismatch("unrequested result kind", result_kind_o, 0);
      end else begin
        want = due_results.pop_front();
        if (result_kind_o !== want.kind) report_mismatch("kind", result_kind_o, want.kind);
        if (dest_net_o !== want.dest) report_mismatch("dest_net", dest_net_o, want.dest);
        if (seq_num_o !== want.seq) report_mismatch("seq_num", seq_num_o, want.seq);
        if (section_addr_o !== want.addr)
          report_mismatch("section_addr", section_addr_o, want.addr);
        if (section_length_o !== want.len)
          report_mismatch("section_length", section_length_o, want.len);
        if (reported_size_o !== want.size)
          report_mismatch("reported_size", reported_size_o, want.size);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  // watchdog on cycles with no request or result moving either way
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("windowed_section_sender_test: done, errors");
        $finish;
      end
    end
  end

  task automatic queue_req(input logic [1:0] cmd, input logic [7:0] net, input logic [2:0] code,
                           input logic [31:0] addr, input logic [15:0] size);
    req_t r;
    r.cmd = cmd;
    r.net = net;
    r.code = code;
    r.addr = addr;
    r.size = size;
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return 16'($urandom);
      2: return 16'($urandom_range(1, 6));
      default: return 16'($urandom_range(1, 120));
    endcase
  endfunction

  // start, capture, then a random mix of ticks, flow reports and other requests
  task automatic add_session(input int steps, input int pause_run);
    logic [7:0] net;
    int n;
    int k;
    net = 8'($urandom);
    queue_req(CMD_START, net, 3'($urandom_range(0, 2)), $urandom, 16'($urandom));
    queue_req(CMD_CAPTURE, 8'($urandom), 3'($urandom), $urandom, pick_size());
    for (n = 0; n < steps; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8:
          queue_req(CMD_TICK, 8'($urandom), 3'($urandom), $urandom, 16'($urandom));
        9, 10, 11: queue_req(CMD_REPORT, 8'($urandom), FLOW_SEND, $urandom, 16'($urandom));
        12, 13: queue_req(CMD_REPORT, 8'($urandom), FLOW_WAIT, $urandom, 16'($urandom));
        14: queue_req(CMD_REPORT, 8'($urandom), FLOW_RESEND, $urandom, 16'($urandom));
        15: queue_req(CMD_CAPTURE, 8'($urandom), 3'($urandom), $urandom, pick_size());
        16: queue_req(CMD_START, 8'($urandom), 3'($urandom), $urandom, 16'($urandom));
        17: queue_req(CMD_REPORT, 8'($urandom), 3'($urandom), $urandom, 16'($urandom));
        18: queue_req(2'($urandom), 8'($urandom), 3'($urandom), $urandom, 16'($urandom));
        default: begin
          for (k = $urandom_range(1, pause_run); k > 0; k--)
            queue_req(CMD_TICK, 8'($urandom), 3'($urandom), $urandom, 16'($urandom));
        end
      endcase
    end
    if ($urandom_range(0, 1) == 0)
      queue_req(CMD_REPORT, 8'($urandom), 3'($urandom_range(FLOW_DONE, FLOW_ABORT)),
                $urandom, 16'($urandom));
  endtask

  task automatic random_items(input int count);
    int goal;
    goal = items_queued + count;
    while (items_queued < goal) begin
      if ($urandom_range(0, 5) == 0)
        queue_req(2'($urandom), 8'($urandom), 3'($urandom), $urandom, 16'($urandom));
      else
        add_session($urandom_range(3, 20), int'(pause_lim) + 2);
    end
  endtask

  // all requests taken and answered, then let the back stage settle
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || push || due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_pause_limit(input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    pause_lim = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int k;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ticks, reports and captures while disarmed are dropped; starts with a bad code get a parameter error
    queue_req(CMD_TICK, 8'h00, 3'd0, 32'h0, 16'h0);
    queue_req(CMD_REPORT, 8'h11, FLOW_SEND, 32'h0, 16'h0);
    queue_req(CMD_CAPTURE, 8'h00, 3'd0, 32'hDEADBEEF, 16'd10);
    queue_req(CMD_START, 8'h01, 3'd3, 32'h0, 16'h0);
    queue_req(CMD_START, 8'h80, 3'd7, 32'hFFFFFFFF, 16'hFFFF);
    queue_req(CMD_START, 8'hFF, 3'd0, 32'h0, 16'hFFFF);
    queue_req(CMD_START, 8'h00, 3'd2, 32'h0, 16'h0);
    queue_req(CMD_TICK, 8'h00, 3'd0, 32'h0, 16'h0);
    // base near the top so section addresses wrap
    queue_req(CMD_CAPTURE, 8'h00, 3'd0, 32'hFFFFFFF0, 16'd50);
    queue_req(CMD_TICK, 8'h00, 3'd0, 32'h0, 16'h0);
    queue_req(CMD_REPORT, 8'h22, FLOW_WAIT, 32'h0, 16'h0);
    queue_req(CMD_TICK, 8'h00, 3'd0, 32'h0, 16'h0);
    queue_req(CMD_REPORT, 8'h22, FLOW_RESEND, 32'h0, 16'h0);
    queue_req(CMD_TICK, 8'h00, 3'd0, 32'h0, 16'h0);
    queue_req(CMD_REPORT, 8'h33, FLOW_SEND, 32'h0, 16'h0);
    queue_req(CMD_TICK, 8'hFF, 3'd7, 32'hFFFFFFFF, 16'hFFFF);
    // buffer used up: complete alarm, then the next tick disarms
    queue_req(CMD_REPORT, 8'h44, FLOW_WAIT, 32'h0, 16'h0);
    queue_req(CMD_TICK, 8'h00, 3'd0, 32'h0, 16'h0);
    queue_req(CMD_START, 8'h5A, 3'd1, 32'h0, 16'h1234);
    queue_req(CMD_CAPTURE, 8'h00, 3'd0, 32'h0, 16'h0);
    queue_req(CMD_TICK, 8'h00, 3'd0, 32'h0, 16'h0);
    queue_req(CMD_REPORT, 8'h5A, 3'd5, 32'h0, 16'h0);
    queue_req(CMD_REPORT, 8'h5A, 3'd7, 32'h0, 16'h0);
    queue_req(CMD_REPORT, 8'h5A, FLOW_DONE, 32'h0, 16'h0);
    queue_req(CMD_START, 8'hA5, 3'd2, 32'h0, 16'h0);
    queue_req(CMD_CAPTURE, 8'h00, 3'd0, 32'h12345678, 16'hFFFF);
    queue_req(CMD_TICK, 8'h00, 3'd0, 32'h0, 16'h0);
    queue_req(CMD_REPORT, 8'hA5, FLOW_ABORT, 32'h0, 16'h0);
    wait_quiet();

    write_pause_limit(8'd1);
    random_items(50);
    wait_quiet();

    // longest pause before the alarm
    write_pause_limit(8'd255);
    queue_req(CMD_REPORT, 8'h00, FLOW_ABORT, 32'h0, 16'h0);
    queue_req(CMD_START, 8'h77, 3'd0, 32'h0, 16'd100);
    queue_req(CMD_CAPTURE, 8'h00, 3'd0, $urandom, 16'd100);
    for (k = 0; k < 257; k++) queue_req(CMD_TICK, 8'h00, 3'd0, 32'h0, 16'h0);
    random_items(20);
    wait_quiet();

    write_pause_limit(8'($urandom_range(2, 40)));
    hold_req = 1;
    random_items(50);
    wait_quiet();

    write_pause_limit(8'd35);
    random_items(50);
    wait_quiet();

    write_pause_limit(8'd3);
    random_items(50);

    while (pending_reqs.size() != 0 || push || due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("windowed_section_sender_test: done, clean");
    end else begin
      $display("windowed_section_sender_test: done, errors");
    end
    $finish;
  end

endmodule
